FILE: hdl/aftm_pkg.sv
// shared types, constants and stage map for the filmic tone map pipeline
package aftm_pkg;

    // pipeline layout: stage 0 input matrix, 1..22 curve and divide, 23..26 output side
    localparam int NUM_STG  = 27;
    localparam int CRV_STG  = 22;
    localparam int DIV_BITS = 18;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic signed [15:0] red_out;
        logic signed [15:0] green_out;
        logic signed [15:0] blue_out;
    } t_pix_out;

    // input matrix, unsigned q0.16, each row sums to one
    localparam logic [15:0] IN_MAT [3][3] = '{
        '{16'd39137, 16'd23238, 16'd3161},
        '{16'd4981,  16'd59529, 16'd1026},
        '{16'd1861,  16'd8771,  16'd54904}
    };

    // output matrix, signed q.16
    localparam logic signed [17:0] OUT_MAT [3][3] = '{
        '{18'sd105169, -18'sd34805, -18'sd4828},
        '{-18'sd6690,  18'sd72622,  -18'sd396},
        '{-18'sd214,   -18'sd4768,  18'sd70518}
    };

    // curve constants, q.16
    localparam logic [24:0] CRV_A    = 25'd1611;
    localparam logic [48:0] CRV_B_SH = 49'd393216;
    localparam logic [39:0] CRV_C    = 40'd64470;
    localparam logic [24:0] CRV_D    = 25'd28374;
    localparam logic [49:0] CRV_E_SH = 50'd1022558208;

    localparam logic [15:0] GAIN_RST = 16'd7373;

endpackage

FILE: hdl/aftm_curve.sv
// one color lane: rational tone curve with a bit-per-stage restoring divider
module aftm_curve (
    input  logic                          i_clk,
    input  logic [aftm_pkg::CRV_STG-1:0]  i_ld,
    input  logic [31:0]                   i_acc,
    output logic signed [17:0]            o_w
);
    import aftm_pkg::*;

    logic [23:0] n_v;
    logic [23:0] r_v;
    logic [48:0] r_va;
    logic [39:0] r_cv;
    logic        n_neg;
    logic [48:0] n_mag;
    logic [24:0] n_t;
    logic        r_neg2;
    logic [48:0] r_mag2;
    logic [48:0] r_vt;
    logic        r_neg3;
    logic [48:0] r_mag3;
    logic [49:0] r_den3;

    logic [49:0]         r_rem [DIV_BITS];
    logic [49:0]         r_den [DIV_BITS];
    logic [DIV_BITS-1:0] r_q   [DIV_BITS];
    logic                r_ng  [DIV_BITS];

    logic [49:0]         w_rem [DIV_BITS+1];
    logic [49:0]         w_den [DIV_BITS+1];
    logic [DIV_BITS-1:0] w_q   [DIV_BITS+1];
    logic                w_ng  [DIV_BITS+1];

    logic [17:0]         n_wm;
    logic signed [17:0]  r_w;

    // stage 1: round to q8.16, square term and slope product
    assign n_v = 24'((33'(i_acc) + 33'd128) >> 8);

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_v  <= n_v;
            r_va <= 49'(n_v) * 49'({1'b0, n_v} + CRV_A);
            r_cv <= 40'(n_v) * CRV_C;
        end
    end

    // stage 2: numerator sign and magnitude, denominator product
    always_comb begin
        n_neg = r_va < CRV_B_SH;
        n_mag = n_neg ? (CRV_B_SH - r_va) : (r_va - CRV_B_SH);
        n_t   = 25'((r_cv + 40'd32768) >> 16) + CRV_D;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_neg2 <= n_neg;
            r_mag2 <= n_mag;
            r_vt   <= 49'(r_v) * 49'(n_t);
        end
    end

    // stage 3: finish denominator
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_neg3 <= r_neg2;
            r_mag3 <= r_mag2;
            r_den3 <= 50'(r_vt) + CRV_E_SH;
        end
    end

    assign w_rem[0] = {1'b0, r_mag3};
    assign w_den[0] = r_den3;
    assign w_q[0]   = '0;
    assign w_ng[0]  = r_neg3;

    // divider: one quotient bit per stage, one extra bit gives the rounding
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic        ge;
        logic [49:0] diff;
        assign ge   = w_rem[k] >= w_den[k];
        assign diff = ge ? (w_rem[k] - w_den[k]) : w_rem[k];

        always_ff @(posedge i_clk) begin
            if (i_ld[3+k]) begin
                r_rem[k] <= {diff[48:0], 1'b0};
                r_den[k] <= w_den[k];
                r_q[k]   <= {w_q[k][DIV_BITS-2:0], ge};
                r_ng[k]  <= w_ng[k];
            end
        end

        assign w_rem[k+1] = r_rem[k];
        assign w_den[k+1] = r_den[k];
        assign w_q[k+1]   = r_q[k];
        assign w_ng[k+1]  = r_ng[k];
    end

    // last stage: round half up, then restore sign
    assign n_wm = 18'((19'(w_q[DIV_BITS]) + 19'd1) >> 1);

    always_ff @(posedge i_clk) begin
        if (i_ld[CRV_STG-1]) begin
            r_w <= w_ng[DIV_BITS] ? -$signed(n_wm) : $signed(n_wm);
        end
    end

    assign o_w = r_w;

endmodule

FILE: hdl/aces_filmic_tone_map_top.sv
// top level of the filmic tone map pipeline
// Filmic tone mapper for linear HDR pixels: one RGB beat in (unsigned q8.8 per
// channel), one beat out (signed q4.12, rounded and saturated). The pixel goes
// through a fixed 3x3 input matrix, a rational tone curve per channel, a fixed
// 3x3 output matrix and the output gain register (q4.12, 1.8 after reset).
// Throughput is one pixel per clock when the output is not stalled; the pipeline
// depth is set by the 18 stage restoring divider of the curve plus the
// matrix, curve and gain stages around it. Each stage holds its own valid bit
// and fills as soon as the next one frees, so bubbles are squeezed out and
// input beats are still taken while a finished result waits at the output.
// The gain is written through i_cfg_we / i_cfg_data and should only change
// while the pipeline is empty.
module aces_filmic_tone_map_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aftm_pkg::t_pix_in  i_pix,
    output logic               o_valid,
    input  logic               i_ready,
    output aftm_pkg::t_pix_out o_pix,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);
    import aftm_pkg::*;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] ld;

    logic [15:0]        r_gain;
    logic [15:0]        px    [3];
    logic [31:0]        r_acc [3];
    logic signed [17:0] w     [3];
    logic signed [36:0] r_y   [3];
    logic [35:0]        r_plo [3];
    logic signed [33:0] r_phi [3];
    logic signed [53:0] r_p   [3];
    logic signed [15:0] n_res [3];
    t_pix_out           r_out;

    // round half away from zero at bit 32, then clamp to q4.12
    function automatic logic signed [15:0] round_sat(input logic signed [53:0] p);
        logic        neg;
        logic [53:0] mag;
        logic [21:0] rm;
        logic signed [15:0] res;
        neg = p[53];
        mag = neg ? 54'(-p) : 54'(p);
        rm  = 22'((mag + 54'd2147483648) >> 32);
        if (neg) begin
            res = (rm > 22'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, rm}));
        end else begin
            res = (rm > 22'd32767) ? 16'sd32767 : $signed(rm[15:0]);
        end
        return res;
    endfunction

    // stage load enables: a stage takes new data when empty or when it drains
    always_comb begin
        ld[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int k = NUM_STG-2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld[0] = ld[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = ld[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_gain <= GAIN_RST;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    assign px[0] = i_pix.red_in;
    assign px[1] = i_pix.green_in;
    assign px[2] = i_pix.blue_in;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        // stage 0: input matrix, sum stays below 2^32
        always_ff @(posedge i_clk) begin
            if (ld[0]) begin
                r_acc[l] <= 32'(IN_MAT[l][0]) * 32'(px[0])
                          + 32'(IN_MAT[l][1]) * 32'(px[1])
                          + 32'(IN_MAT[l][2]) * 32'(px[2]);
            end
        end

        // stages 1..22: tone curve
        aftm_curve u_crv (
            .i_clk (i_clk),
            .i_ld  (ld[CRV_STG:1]),
            .i_acc (r_acc[l]),
            .o_w   (w[l])
        );

        // stage 23: output matrix
        always_ff @(posedge i_clk) begin
            if (ld[CRV_STG+1]) begin
                r_y[l] <= 37'(OUT_MAT[l][0]) * 37'(w[0])
                        + 37'(OUT_MAT[l][1]) * 37'(w[1])
                        + 37'(OUT_MAT[l][2]) * 37'(w[2]);
            end
        end

        // stage 24: gain as two partial products
        always_ff @(posedge i_clk) begin
            if (ld[CRV_STG+2]) begin
                r_plo[l] <= 36'(r_y[l][19:0]) * 36'(r_gain);
                r_phi[l] <= 34'($signed(r_y[l][36:20])) * 34'($signed({1'b0, r_gain}));
            end
        end

        // stage 25: recombine
        always_ff @(posedge i_clk) begin
            if (ld[CRV_STG+3]) begin
                r_p[l] <= (54'(r_phi[l]) <<< 20) + $signed({18'd0, r_plo[l]});
            end
        end

        assign n_res[l] = round_sat(r_p[l]);
    end

    // stage 26: output register
    always_ff @(posedge i_clk) begin
        if (ld[NUM_STG-1]) begin
            r_out.red_out   <= n_res[0];
            r_out.green_out <= n_res[1];
            r_out.blue_out  <= n_res[2];
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_vld[NUM_STG-1];
    assign o_pix   = r_out;

`ifndef SYNTHESIS
    // input backpressure only comes from a stalled, full output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output stall");

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted beat lost at entry");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

FILE: sim/aftm_checker.sv
// watches both channels, predicts every tone mapped pixel and compares it
`timescale 1ns / 1ps

module aftm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  aftm_pkg::t_pix_in  i_pix,
    input  logic               o_valid,
    input  logic               i_ready,
    input  aftm_pkg::t_pix_out o_pix,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    import aftm_pkg::*;

    localparam longint unsigned M_IN [3][3] = '{
        '{39137, 23238, 3161}, '{4981, 59529, 1026}, '{1861, 8771, 54904}};
    localparam longint M_OUT [3][3] = '{
        '{105169, -34805, -4828}, '{-6690, 72622, -396}, '{-214, -4768, 70518}};

    logic [15:0] gain_q412;
    t_pix_out    pix_expected [$];

    // rational curve per channel, q.16 in and out
    function automatic longint filmic_curve(longint unsigned v);
        longint          num;
        longint unsigned t, den, mag;
        logic [79:0]     nn, q, r;
        num = longint'(v * (v + 1611)) - (longint'(6) <<< 16);
        t   = ((64470 * v + 32768) >> 16) + 28374;
        den = v * t + (64'd15603 << 16);
        mag = (num < 0) ? longint'(-num) : longint'(num);
        nn  = {mag, 16'b0};
        q   = nn / den;
        r   = nn % den;
        if (2 * r >= den) q = q + 1;
        return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_pix_out tone_map(t_pix_in px, logic [15:0] g);
        longint unsigned ch [3];
        longint unsigned acc;
        longint          w [3];
        longint          y, prod, r;
        logic [15:0]     res [3];
        t_pix_out        o;
        ch = '{px.red_in, px.green_in, px.blue_in};
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += M_IN[i][j] * ch[j];
            w[i] = filmic_curve((acc + 128) >> 8);
        end
        for (int i = 0; i < 3; i++) begin
            y = 0;
            for (int j = 0; j < 3; j++) y += M_OUT[i][j] * w[j];
            prod = y * longint'({48'b0, g});
            // round half away from zero
            if (prod < 0) r = -((-prod + (longint'(1) <<< 31)) >>> 32);
            else          r = (prod + (longint'(1) <<< 31)) >>> 32;
            if (r > 32767)  r = 32767;
            if (r < -32768) r = -32768;
            res[i] = r[15:0];
        end
        o.red_out   = res[0];
        o.green_out = res[1];
        o.blue_out  = res[2];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_pix_out exp_pix;
        if (!i_rst_n) begin
            gain_q412 <= GAIN_RST;
            pix_expected.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_we) gain_q412 <= i_cfg_data;
            if (i_valid && o_ready) pix_expected.push_back(tone_map(i_pix, gain_q412));
            if (o_valid && i_ready) begin
                if (pix_expected.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected beat %h", o_pix);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_pix = pix_expected.pop_front();
                    if (exp_pix !== o_pix) begin
                        if (o_fail_cnt < 10)
                            $display("mismatch r/g/b exp %0d %0d %0d got %0d %0d %0d",
                                exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out,
                                o_pix.red_out, o_pix.green_out, o_pix.blue_out);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

    assign o_pending = pix_expected.size();

endmodule

FILE: sim/tb.sv
// stimulus and verdict for the filmic tone map pipeline
`timescale 1ns / 1ps

module tb;
    import aftm_pkg::*;

    localparam int DRAIN_CYC = 40;      // pipeline is 27 deep
    localparam int CYC_LIMIT = 2000000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_pix_in  i_pix = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_pix_out o_pix;
    logic     i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    int       fail_cnt, pending, cyc_cnt = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    aces_filmic_tone_map_top i_dut (.*);

    aftm_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pix, .o_valid, .i_ready, .o_pix,
        .i_cfg_we, .i_cfg_data, .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // hard stop in case the pipeline hangs
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side back-pressure: ready held for random stretches
    initial begin
        int hold;
        int mode;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                i_ready <= 1'b1;
                hold = $urandom_range(1, 60);   // free-flowing stretch
            end else if (mode < 9) begin
                i_ready <= 1'($urandom_range(0, 1));
                hold = $urandom_range(1, 3);
            end else begin
                i_ready <= 1'b0;
                hold = $urandom_range(10, 40);  // long stall
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    // one pixel beat, with a random gap ahead of it; valid stays up without a gap
    task automatic send_pixel(input logic [15:0] r, g, b);
        int sel;
        int gap;
        sel = $urandom_range(0, 99);
        gap = 0;
        if (sel >= 90) gap = $urandom_range(10, 40);
        else if (sel >= 55) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= '{red_in: r, green_in: g, blue_in: b};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // channel value: mostly the useful low range, sometimes anything
    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 255));     // below 1.0
            2:       return 16'($urandom_range(0, 4095));    // up to 16.0
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    // gain change only with the pipeline empty and quiet
    task automatic set_gain(input logic [15:0] g);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [15:0] gains [6];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats at the reset gain of 1.8
        send_pixel(16'd0, 16'd0, 16'd0);            // zero input, small negatives
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);   // brightest
        send_pixel(16'hFFFF, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'd0, 16'hFFFF);
        send_pixel(16'd256, 16'd256, 16'd256);      // 1.0 grey
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd256, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd256);
        send_pixel(16'h5555, 16'hAAAA, 16'h0F0F);
        send_pixel(16'hAAAA, 16'h5555, 16'hF0F0);

        gains = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd0, 16'd7373};
        gains[4] = 16'($urandom_range(0, 65535));
        for (int ph = 0; ph < 6; ph++) begin
            set_gain(gains[ph]);
            if (ph == 1) begin
                send_pixel(16'd0, 16'd0, 16'd0);
                send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
            end
            for (int n = 0; n < 290; n++) send_pixel(rand_chan(), rand_chan(), rand_chan());
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
